### rtl/pwm_generator_duty_frequency_macros.svh
// ----------------------------------------------------------------------------
// PWM generator assertion macros
// Shorthand for the concurrent checks used in the PWM generator.
// ----------------------------------------------------------------------------
`ifndef PWM_GENERATOR_DUTY_FREQUENCY_MACROS_SVH
`define PWM_GENERATOR_DUTY_FREQUENCY_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define PGDF_ASSERT_IMPL(label, cond, prop) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (prop)) \
    else $error("pwm generator check failed");

// Next-cycle implication, disabled during reset.
`define PGDF_ASSERT_NEXT(label, cond, prop) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (prop)) \
    else $error("pwm generator check failed");

`endif

### rtl/pgdf_pkg.sv
// ----------------------------------------------------------------------------
// PWM generator package
// Types and constants shared by the PWM generator.
// ----------------------------------------------------------------------------
package pgdf_pkg;

  typedef enum logic [4:0] {
    ST_IDLE = 5'b00001,
    ST_DIVP = 5'b00010,
    ST_MUL  = 5'b00100,
    ST_DIVH = 5'b01000,
    ST_DONE = 5'b10000
  } pgdf_state_t;

  // Register index, taken from paddr[2].
  localparam logic REG_DUTY = 1'b0;
  localparam logic REG_FREQ = 1'b1;

  localparam logic [7:0]  DUTY_RESET = 8'd128;
  localparam logic [15:0] FREQ_RESET = 16'd490;
  localparam logic [15:0] DUTY_FULL  = 16'd255;
  localparam logic [15:0] PERIOD_MAX = 16'hFFFF;

endpackage

### rtl/pwm_generator_duty_frequency.sv
// ----------------------------------------------------------------------------
// PWM generator with 8-bit duty and frequency in hertz
// One tick in, one line value out. The period and high time are reloaded
// from the registers at each period start: a shared bit-serial divider gives
// the period and a shift-and-add reciprocal gives the division by 255.
// ----------------------------------------------------------------------------
// Channel   Direction  Handshake            Payload
// in        input      in_valid / in_stall  stop_request
// out       output     out_valid/out_stall  line_level, period_start, is_stopped
// cfg       APB        psel/penable/pready  paddr[2:0], pwdata, prdata
//
// An ordinary tick goes straight into the result register. A tick at a
// period start runs DIV_W restoring divider steps, then the duty product,
// the divide by 255 and the posting of the result, which waits for the
// result register to be free.
// Reset is synchronous; the first tick after reset loads the timing.
// A result register and an output register part the two sides, so one
// tick can be taken while a result waits on a stalled output.
// ----------------------------------------------------------------------------
`include "pwm_generator_duty_frequency_macros.svh"

module pwm_generator_duty_frequency #(
  parameter int TICKS_PER_SECOND = 1000000
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        stop_request,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        line_level,
  output logic        period_start,
  output logic        is_stopped,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import pgdf_pkg::*;

  localparam int TPS_W = $clog2(TICKS_PER_SECOND + 1);
  localparam int DIV_W = (TPS_W > 24) ? TPS_W : 24;
  localparam int CNT_W = $clog2(DIV_W + 1);
  localparam logic [DIV_W-1:0] TPS_VAL = DIV_W'(TICKS_PER_SECOND);

  pgdf_state_t state;

  logic [7:0]  duty_level;
  logic [15:0] frequency_hz;
  logic [15:0] tick_in_period;
  logic [15:0] period_ticks;
  logic [15:0] high_ticks;
  logic        stopped;

  // Shared divider: dividend shifts out at the top while quotient bits enter.
  logic [DIV_W-1:0] dq;
  logic [15:0]      rem;
  logic [15:0]      divisor;
  logic [CNT_W-1:0] cnt;

  logic             res_valid;
  logic             res_line;
  logic             res_start;
  logic             res_stop;

  logic [16:0]      partial;
  logic             fits;
  logic [16:0]      diff;
  logic [15:0]      rem_step;
  logic [DIV_W-1:0] dq_step;
  logic [15:0]      period_sat;
  logic [23:0]      prod;
  logic [48:0]      recip;
  logic [16:0]      tick_inc;
  logic             res_move;
  logic             res_load;
  logic             in_accept;
  logic             cfg_write;

  assign partial  = {rem, dq[DIV_W-1]};
  assign fits     = partial >= {1'b0, divisor};
  assign diff     = partial - {1'b0, divisor};
  assign rem_step = fits ? diff[15:0] : partial[15:0];
  assign dq_step  = {dq[DIV_W-2:0], fits};

  always_comb begin
    if (|dq_step[DIV_W-1:16]) begin
      period_sat = PERIOD_MAX;
    end else if (dq_step[15:0] == 16'd0) begin
      period_sat = 16'd1;
    end else begin
      period_sat = dq_step[15:0];
    end
  end

  assign prod     = {8'd0, period_ticks} * {16'd0, duty_level};
  assign tick_inc = {1'b0, tick_in_period} + 17'd1;

  // Division by 255 as a multiply by 2^32/255 rounded up (0x01010102),
  // exact for every product below 2^24.
  assign recip = {1'b0, dq[23:0], 24'd0} + {9'd0, dq[23:0], 16'd0}
               + {17'd0, dq[23:0], 8'd0} + {24'd0, dq[23:0], 1'b0};

  assign res_move  = res_valid && (!out_valid || !out_stall);
  assign in_stall  = (state != ST_IDLE) || (res_valid && !res_move);
  assign in_accept = in_valid && !in_stall;
  assign res_load  = (state == ST_IDLE)
                   ? (in_accept && (stop_request || stopped || (tick_in_period != 16'd0)))
                   : ((state == ST_DONE) && (!res_valid || res_move));

  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;

  always_comb begin
    unique case (paddr[2])
      REG_DUTY: prdata = {24'd0, duty_level};
      REG_FREQ: prdata = {16'd0, frequency_hz};
      default:  prdata = 32'd0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      duty_level   <= DUTY_RESET;
      frequency_hz <= FREQ_RESET;
    end else if (cfg_write) begin
      unique case (paddr[2])
        REG_DUTY: duty_level   <= pwdata[7:0];
        REG_FREQ: frequency_hz <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= ST_IDLE;
      tick_in_period <= 16'd0;
      stopped        <= 1'b0;
      res_valid      <= 1'b0;
    end else begin
      if (res_load) begin
        res_valid <= 1'b1;
      end else if (res_move) begin
        res_valid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (in_accept) begin
            if (stop_request || stopped) begin
              stopped   <= 1'b1;
              res_line  <= 1'b0;
              res_start <= 1'b0;
              res_stop  <= 1'b1;
            end else if (tick_in_period == 16'd0) begin
              dq      <= TPS_VAL;
              rem     <= 16'd0;
              divisor <= (frequency_hz == 16'd0) ? 16'd1 : frequency_hz;
              cnt     <= CNT_W'(DIV_W);
              state   <= ST_DIVP;
            end else begin
              res_line  <= tick_in_period < high_ticks;
              res_start <= 1'b0;
              res_stop  <= 1'b0;
              tick_in_period <= (tick_inc >= {1'b0, period_ticks}) ? 16'd0
                                                                   : tick_inc[15:0];
            end
          end
        end
        ST_DIVP: begin
          dq  <= dq_step;
          rem <= rem_step;
          cnt <= cnt - CNT_W'(1);
          if (cnt == CNT_W'(1)) begin
            period_ticks <= period_sat;
            state        <= ST_MUL;
          end
        end
        ST_MUL: begin
          dq    <= DIV_W'(prod);
          state <= ST_DIVH;
        end
        ST_DIVH: begin
          high_ticks <= recip[47:32];
          state      <= ST_DONE;
        end
        ST_DONE: begin
          // The period-start tick is the first of the period: position zero.
          if (!res_valid || res_move) begin
            res_line       <= high_ticks != 16'd0;
            res_start      <= 1'b1;
            res_stop       <= 1'b0;
            tick_in_period <= (period_ticks == 16'd1) ? 16'd0 : 16'd1;
            state          <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res_move) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_move) begin
      line_level   <= res_line;
      period_start <= res_start;
      is_stopped   <= res_stop;
    end
  end

  `PGDF_ASSERT_NEXT(a_stop_sticky, stopped, stopped)
  `PGDF_ASSERT_IMPL(a_tick_range, (state == ST_IDLE) && !stopped && (tick_in_period != 16'd0), tick_in_period < period_ticks)
  `PGDF_ASSERT_IMPL(a_period_nonzero, state == ST_MUL, period_ticks != 16'd0)
  `PGDF_ASSERT_IMPL(a_high_le_period, state == ST_DONE, high_ticks <= period_ticks)

endmodule

### test/pwm_generator_duty_frequency_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// PWM generator testbench
// Feeds ticks to the PWM generator under random source gaps and sink stalls,
// predicts the line level, period start and stop flag of every tick, and
// compares each result transaction with the prediction. Register settings
// change between phases, cover both duty extremes, the start of a saturated
// period and the permanent stop at the end of the run.
// ----------------------------------------------------------------------------
module pwm_generator_duty_frequency_tb;
  import pgdf_pkg::*;

  localparam int TICKS_PER_SEC = 1000000;
  localparam int GAP_MAX = 10;
  localparam int WATCHDOG_LIMIT = 5000;
  localparam int DRAIN_CYCLES = 60;
  localparam int PRINT_LIMIT = 50;
  localparam int SAT_TICKS = 280;
  localparam logic [2:0] DUTY_ADDR = {REG_DUTY, 2'b00};
  localparam logic [2:0] FREQ_ADDR = {REG_FREQ, 2'b00};

  typedef struct {
    bit          stop;
    int unsigned gap;
  } tick_item_t;

  typedef struct packed {
    logic line;
    logic start;
    logic stopped;
  } tick_result_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic        stop_request = 1'b0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic        line_level;
  logic        period_start;
  logic        is_stopped;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [2:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  // Predictor state and its copy of the registers.
  logic [7:0]  duty_cfg;
  logic [15:0] freq_cfg;
  logic [15:0] tick_pos;
  logic [15:0] period_len;
  logic [15:0] high_len;
  bit          halted;

  tick_item_t   tick_q[$];
  tick_result_t pending_results[$];
  tick_item_t   cur_tick;
  tick_result_t want;

  int unsigned gap_left = 0;
  int unsigned cur_gap = 0;
  int unsigned hold_left = 0;
  int unsigned quiet_cycles = 0;
  int unsigned errors = 0;
  int unsigned ticks_sent = 0;
  int unsigned results_checked = 0;
  int unsigned starts_seen = 0;
  int unsigned settings = 0;
  bit          sink_calm = 1'b0;

  pwm_generator_duty_frequency #(
    .TICKS_PER_SECOND(TICKS_PER_SEC)
  ) dut (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .stop_request(stop_request),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .line_level(line_level),
    .period_start(period_start),
    .is_stopped(is_stopped),
    .psel(psel),
    .penable(penable),
    .pwrite(pwrite),
    .paddr(paddr),
    .pwdata(pwdata),
    .prdata(prdata),
    .pready(pready)
  );

  always #1 clk = ~clk;

  function automatic void reload_timing();
    logic [31:0] hz;
    logic [31:0] span;
    hz = (freq_cfg == 16'd0) ? 32'd1 : {16'd0, freq_cfg};
    span = TICKS_PER_SEC / hz;
    if (span > PERIOD_MAX) span = PERIOD_MAX;
    if (span == 32'd0) span = 32'd1;
    period_len = span[15:0];
    high_len = 16'((span * duty_cfg) / DUTY_FULL);
  endfunction

  function automatic tick_result_t compute_tick_output(bit stop);
    tick_result_t r;
    r = '0;
    if (stop) halted = 1'b1;
    if (halted) begin
      r.stopped = 1'b1;
      return r;
    end
    // The timing is latched only at a period start.
    if (tick_pos == 16'd0) begin
      reload_timing();
      r.start = 1'b1;
    end
    r.line = (tick_pos < high_len);
    tick_pos = tick_pos + 16'd1;
    if (tick_pos >= period_len) tick_pos = 16'd0;
    return r;
  endfunction

  task automatic report_mismatch(string msg);
    errors++;
    if (errors <= PRINT_LIMIT) $display("%0t: result %0d: %s", $time, results_checked, msg);
  endtask

  // Source side: one tick transaction at a time, with a drawn gap after each.
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
      stop_request <= 1'b0;
      gap_left = 0;
    end else begin
      if (in_valid && !in_stall) begin
        pending_results.push_back(compute_tick_output(stop_request));
        ticks_sent++;
        gap_left = cur_gap;
      end
      if (!(in_valid && in_stall)) begin
        if (gap_left != 0) begin
          gap_left--;
          in_valid <= 1'b0;
        end else if (tick_q.size() != 0) begin
          cur_tick = tick_q.pop_front();
          cur_gap = cur_tick.gap;
          in_valid <= 1'b1;
          stop_request <= cur_tick.stop;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Sink side: check each result transaction, then stall for a drawn count.
  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
      hold_left = 0;
    end else begin
      if (out_valid && !out_stall) begin
        if (pending_results.size() == 0) begin
          report_mismatch("result with no tick waiting for it");
        end else begin
          want = pending_results.pop_front();
          if (line_level !== want.line)
            report_mismatch($sformatf("line_level %b, predicted %b", line_level, want.line));
          if (period_start !== want.start)
            report_mismatch($sformatf("period_start %b, predicted %b", period_start,
                                      want.start));
          if (is_stopped !== want.stopped)
            report_mismatch($sformatf("is_stopped %b, predicted %b", is_stopped,
                                      want.stopped));
          if (want.start) starts_seen++;
        end
        results_checked++;
        hold_left = sink_calm ? 0 : $urandom_range(0, GAP_MAX);
      end
      if (hold_left != 0) begin
        out_stall <= 1'b1;
        hold_left--;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == WATCHDOG_LIMIT) begin
      $display("%0t: no transaction for %0d cycles, %0d results outstanding", $time,
               WATCHDOG_LIMIT, pending_results.size());
      $display("end of test: mismatches");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic apb_write(logic [2:0] addr, logic [31:0] data);
    @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= addr;
    pwdata <= data;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  task automatic wait_drained();
    while (tick_q.size() != 0 || in_valid || pending_results.size() != 0) @(negedge clk);
  endtask

  // Called only with nothing in flight; every tick has already returned.
  task automatic set_pwm(logic [7:0] duty, logic [15:0] freq);
    repeat (4) @(negedge clk);
    apb_write(DUTY_ADDR, {24'd0, duty});
    duty_cfg = duty;
    apb_write(FREQ_ADDR, {16'd0, freq});
    freq_cfg = freq;
    settings++;
    @(negedge clk);
  endtask

  task automatic send_ticks(int unsigned count, bit calm, bit random_stop);
    tick_item_t t;
    sink_calm = calm;
    for (int unsigned i = 0; i < count; i++) begin
      t.stop = random_stop ? 1'($urandom_range(0, 1)) : 1'b0;
      t.gap = calm ? 0 : $urandom_range(0, GAP_MAX);
      tick_q.push_back(t);
    end
    wait_drained();
  endtask

  initial begin
    logic [7:0]  duty;
    logic [15:0] freq;
    int unsigned leftover;
    tick_item_t  stop_tick;

    duty_cfg = DUTY_RESET;
    freq_cfg = FREQ_RESET;
    tick_pos = 16'd0;
    halted = 1'b0;
    reload_timing();

    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Shortest period at both duty extremes: the line must never toggle.
    set_pwm(8'd255, 16'd65535);
    send_ticks(16, 1'b0, 1'b0);
    set_pwm(8'd0, 16'd65535);
    send_ticks(16, 1'b0, 1'b0);

    for (int k = 0; k < 6; k++) begin
      case ($urandom_range(0, 5))
        0: duty = 8'd0;
        1: duty = 8'd255;
        2: duty = 8'd1;
        3: duty = 8'd254;
        default: duty = 8'($urandom_range(0, 255));
      endcase
      freq = 16'($urandom_range(10000, 65535));
      set_pwm(duty, freq);
      send_ticks($urandom_range(20, 40), k == 3, 1'b0);
    end

    // Frequency zero saturates the period. At duty 1 the line falls after
    // 257 ticks of it, which only the saturated length gives. That period
    // outlasts the run, so the setting after it is never latched.
    set_pwm(8'd1, 16'd0);
    leftover = (tick_pos == 16'd0) ? 0 : period_len - tick_pos;
    send_ticks(leftover + SAT_TICKS, 1'b1, 1'b0);

    set_pwm(8'd100, 16'd31);
    send_ticks(20, 1'b0, 1'b0);

    // Stop for good, then keep ticking with both stop values.
    stop_tick.stop = 1'b1;
    stop_tick.gap = $urandom_range(0, GAP_MAX);
    tick_q.push_back(stop_tick);
    send_ticks(12, 1'b0, 1'b1);

    repeat (DRAIN_CYCLES) @(negedge clk);

    $display("Ran %0d ticks over %0d register settings, from the shortest period at", ticks_sent,
             settings);
    $display("both duty extremes into a saturated period and a final stop; %0d results,",
             results_checked);
    $display("%0d period starts checked", starts_seen);
    if (errors == 0 && pending_results.size() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("%0d mismatches, %0d results missing", errors, pending_results.size());
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

### pwm_generator_duty_frequency.f
+incdir+rtl
rtl/pgdf_pkg.sv
rtl/pwm_generator_duty_frequency.sv
test/pwm_generator_duty_frequency_tb.sv
